// ----- rtl/sle_pkg.sv -----
// sle_pkg: shared types, constants and the system color table for the sprite unit
// no dependencies; imported by every rtl module of the block
`default_nettype none

package sle_pkg;

    localparam int OBJECT_COUNT     = 64;
    localparam int SPRITES_PER_LINE = 8;
    localparam int PATTERN_BYTES    = 8192;

    localparam int OBJ_W  = $clog2(OBJECT_COUNT);
    localparam int SLOT_W = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;
    localparam int CNT_W  = $clog2(SPRITES_PER_LINE + 1);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);

    // item function codes
    typedef logic [2:0] t_func;
    localparam t_func FN_OAM_WR = 3'd0;
    localparam t_func FN_PAT_WR = 3'd1;
    localparam t_func FN_PAL_WR = 3'd2;
    localparam t_func FN_EVAL   = 3'd3;
    localparam t_func FN_PIXEL  = 3'd4;
    localparam t_func FN_CLEAR  = 3'd5;

    // configuration register indexes
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_TALL       = 3'd0;
    localparam t_reg_idx REG_TABLE_HIGH = 3'd1;
    localparam t_reg_idx REG_SHOW_LEFT  = 3'd2;
    localparam t_reg_idx REG_SHOW_BG    = 3'd3;
    localparam t_reg_idx REG_SHOW_SPR   = 3'd4;

    localparam logic [7:0] LAST_VISIBLE_TOP = 8'd239;
    localparam logic [9:0] PRE_RENDER_LINE  = 10'h3FF;
    localparam logic [7:0] LAST_COLUMN      = 8'd255;

    typedef struct packed {
        logic tall;
        logic table_high;
        logic show_left;
        logic show_bg;
        logic show_spr;
    } t_cfg;

    typedef struct packed {
        t_func       func;
        logic [12:0] address;
        logic [7:0]  data;
        logic [7:0]  pixel_x;
        logic [9:0]  line;
        logic [3:0]  bg_index;
    } t_item;

    typedef struct packed {
        logic load;
        logic exec;
        logic ev_rd;
        logic ev_take;
        logic px_next;
        logic px_rd_lo;
        logic px_rd_hi;
        logic px_eval;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  ev_end;
        logic  px_none;
        logic  px_skip;
    } t_sts;

    typedef struct packed {
        logic        drawn;
        logic [5:0]  cidx;
        logic [23:0] rgb;
        logic        hit;
        logic [3:0]  count;
    } t_result;

    function automatic logic [23:0] sys_color(input logic [5:0] idx);
        logic [23:0] c;
        case (idx)
            6'd0:  c = 24'h7C7C7C; 6'd1:  c = 24'h0000FC; 6'd2:  c = 24'h0000BC;
            6'd3:  c = 24'h4428BC; 6'd4:  c = 24'h940084; 6'd5:  c = 24'hA80020;
            6'd6:  c = 24'hA81000; 6'd7:  c = 24'h881400; 6'd8:  c = 24'h503000;
            6'd9:  c = 24'h007800; 6'd10: c = 24'h006800; 6'd11: c = 24'h005800;
            6'd12: c = 24'h004058; 6'd16: c = 24'hBCBCBC; 6'd17: c = 24'h0078F8;
            6'd18: c = 24'h0058F8; 6'd19: c = 24'h6844FC; 6'd20: c = 24'hD800CC;
            6'd21: c = 24'hE40058; 6'd22: c = 24'hF83800; 6'd23: c = 24'hE45C10;
            6'd24: c = 24'hAC7C00; 6'd25: c = 24'h00B800; 6'd26: c = 24'h00A800;
            6'd27: c = 24'h00A844; 6'd28: c = 24'h008888; 6'd32: c = 24'hF8F8F8;
            6'd33: c = 24'h3CBCFC; 6'd34: c = 24'h6888FC; 6'd35: c = 24'h9878F8;
            6'd36: c = 24'hF878F8; 6'd37: c = 24'hF85898; 6'd38: c = 24'hF87858;
            6'd39: c = 24'hFCA044; 6'd40: c = 24'hF8B800; 6'd41: c = 24'hB8F818;
            6'd42: c = 24'h58D854; 6'd43: c = 24'h58F898; 6'd44: c = 24'h00E8D8;
            6'd45: c = 24'h787878; 6'd48: c = 24'hFCFCFC; 6'd49: c = 24'hA4E4FC;
            6'd50: c = 24'hB8B8F8; 6'd51: c = 24'hD8B8F8; 6'd52: c = 24'hF8B8F8;
            6'd53: c = 24'hF8A4C0; 6'd54: c = 24'hF0D0B0; 6'd55: c = 24'hFCE0A8;
            6'd56: c = 24'hF8D878; 6'd57: c = 24'hD8F878; 6'd58: c = 24'hB8F8B8;
            6'd59: c = 24'hB8F8D8; 6'd60: c = 24'h00FCFC; 6'd61: c = 24'hF8D8F8;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sle_ctrl.sv -----
// sle_ctrl: sequencer of the sprite unit, issues datapath commands per item
// depends on sle_pkg
`default_nettype none

module sle_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wire            i_out_free,
    input  sle_pkg::t_sts  i_sts,
    output sle_pkg::t_cmd  o_cmd
);
    import sle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DISP, S_EV_RD, S_EV_TAKE, S_PX_CHK, S_PX_HI, S_PX_RES, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.func) inside
                    FN_EVAL:  n_state = S_EV_RD;
                    FN_PIXEL: n_state = S_PX_CHK;
                    default: begin
                        cmd.exec = 1'b1;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_EV_RD: begin
                cmd.ev_rd = 1'b1;
                n_state   = S_EV_TAKE;
            end
            S_EV_TAKE: begin
                cmd.ev_take = 1'b1;
                n_state     = i_sts.ev_end ? S_DONE : S_EV_RD;
            end
            S_PX_CHK: begin
                if (i_sts.px_none) begin
                    n_state = S_DONE;
                end else if (i_sts.px_skip) begin
                    cmd.px_next = 1'b1;
                end else begin
                    cmd.px_rd_lo = 1'b1;
                    n_state      = S_PX_HI;
                end
            end
            S_PX_HI: begin
                cmd.px_rd_hi = 1'b1;
                n_state      = S_PX_RES;
            end
            S_PX_RES: begin
                cmd.px_eval = 1'b1;
                n_state     = S_PX_CHK;
            end
            S_DONE: begin
                if (i_out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

// ----- rtl/sle_dp.sv -----
// sle_dp: object table, pattern memory, palette, line slots and pixel logic
// depends on sle_pkg; driven by sle_ctrl commands
`default_nettype none

module sle_dp (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  sle_pkg::t_item   i_item,
    input  sle_pkg::t_cfg    i_cfg,
    input  sle_pkg::t_cmd    i_cmd,
    output sle_pkg::t_sts    o_sts,
    output sle_pkg::t_result o_result
);
    import sle_pkg::*;

    t_item       r_item;

    logic [7:0]  r_oam_mem [256];
    logic [255:0] r_oam_vld;
    logic [7:0]  r_oam_q;
    logic        r_oam_qv;

    logic [7:0]  r_pat_mem [PATTERN_BYTES];
    logic [7:0]  r_pat_q;
    logic [7:0]  r_pat_lo;

    logic [7:0]  r_pal [32];

    logic [31:0] r_slot [SPRITES_PER_LINE];
    logic [SPRITES_PER_LINE-1:0] r_slot_zero;
    logic [CNT_W-1:0] r_count;

    logic [OBJ_W-1:0] r_obj;
    logic [1:0]       r_byte;
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_s;

    logic        r_hit;
    logic        r_drawn;
    logic [5:0]  r_cidx;

    // evaluation
    logic [7:0]  oam_raddr;
    logic [7:0]  oam_data;
    logic [10:0] ev_diff;
    logic        ev_in_range;
    logic        obj_last;
    logic        n_last;
    logic        ev_end;
    logic [CNT_W-1:0] n_plus;

    assign oam_raddr = 8'({r_obj, r_byte});
    assign oam_data  = r_oam_qv ? r_oam_q : 8'h00;
    assign ev_diff   = {r_item.line[9], r_item.line} - {3'b000, oam_data} - 11'd1;
    assign ev_in_range = !ev_diff[10] && (ev_diff[9:4] == 6'd0)
                         && (i_cfg.tall || !ev_diff[3]);
    assign obj_last  = (r_obj == OBJ_W'(OBJECT_COUNT - 1));
    assign n_last    = (r_n == CNT_W'(SPRITES_PER_LINE - 1));
    assign n_plus    = r_n + 1'b1;
    assign ev_end    = ((r_byte == 2'd0) && !ev_in_range && obj_last)
                       || ((r_byte == 2'd3) && (obj_last || n_last));

    // pixel walk
    logic [CNT_W-1:0]  s_m1;
    logic [SLOT_W-1:0] s_idx;
    logic [31:0] ent;
    logic [7:0]  e_y, e_tile, e_attr, e_x;
    logic [8:0]  x_diff;
    logic        px_skip;
    logic [3:0]  row4;
    logic        fy, fx, half, flip_row;
    logic [2:0]  row3;
    logic [7:0]  tile_byte;
    logic        base_bit;
    logic [PAT_AW-1:0] pat_raddr;
    logic [2:0]  lx;
    logic [1:0]  color;
    logic [4:0]  pal_ridx;
    logic [4:0]  pal_widx;

    assign s_m1   = r_s - 1'b1;
    assign s_idx  = s_m1[SLOT_W-1:0];
    assign ent    = r_slot[s_idx];
    assign e_y    = ent[7:0];
    assign e_tile = ent[15:8];
    assign e_attr = ent[23:16];
    assign e_x    = ent[31:24];

    assign x_diff  = {1'b0, r_item.pixel_x} - {1'b0, e_x};
    assign px_skip = (e_y >= LAST_VISIBLE_TOP) || x_diff[8] || (x_diff[7:3] != 5'd0)
                     || ((r_item.pixel_x[7:3] == 5'd0) && !i_cfg.show_left);

    assign row4     = r_item.line[3:0] - e_y[3:0] - 4'd1;
    assign fy       = e_attr[7];
    assign fx       = e_attr[6];
    // the lower half of a tall sprite comes from the second tile unless flipped
    assign half     = row4[3] ^ fy;
    assign flip_row = fy & ~(i_cfg.tall & row4[3]);
    assign row3     = row4[2:0] ^ {3{flip_row}};
    assign tile_byte = i_cfg.tall ? {e_tile[7:1], half} : e_tile;
    assign base_bit  = i_cfg.tall ? e_tile[0] : i_cfg.table_high;
    assign pat_raddr = {base_bit, tile_byte, i_cmd.px_rd_hi, row3};

    assign lx       = (r_item.pixel_x[2:0] - e_x[2:0]) ^ {3{fx}};
    assign color    = {r_pat_q[~lx], r_pat_lo[~lx]};
    assign pal_ridx = {1'b1, e_attr[1:0], color};

    // backdrop entries of the sprite half fold onto the background half
    assign pal_widx = (r_item.address[4] && (r_item.address[1:0] == 2'b00))
                      ? {1'b0, r_item.address[3:0]} : r_item.address[4:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // object table
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_item.func == FN_OAM_WR)) begin
            r_oam_mem[r_item.address[7:0]] <= r_item.data;
        end
        if (i_cmd.ev_rd) begin
            r_oam_q <= r_oam_mem[oam_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oam_vld <= '0;
            r_oam_qv  <= 1'b0;
        end else begin
            if (i_cmd.exec && (r_item.func == FN_OAM_WR)) begin
                r_oam_vld[r_item.address[7:0]] <= 1'b1;
            end
            if (i_cmd.ev_rd) begin
                r_oam_qv <= r_oam_vld[oam_raddr];
            end
        end
    end

    // pattern memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_item.func == FN_PAT_WR)) begin
            r_pat_mem[r_item.address[PAT_AW-1:0]] <= r_item.data;
        end
        if (i_cmd.px_rd_lo || i_cmd.px_rd_hi) begin
            r_pat_q <= r_pat_mem[pat_raddr];
        end
        if (i_cmd.px_rd_hi) begin
            r_pat_lo <= r_pat_q;
        end
    end

    // line slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_take) begin
            if (r_byte == 2'd0) begin
                if (ev_in_range) begin
                    r_slot[r_n[SLOT_W-1:0]][7:0]     <= oam_data;
                    r_slot_zero[r_n[SLOT_W-1:0]]     <= (r_obj == '0);
                end
            end else begin
                r_slot[r_n[SLOT_W-1:0]][r_byte*8 +: 8] <= oam_data;
            end
        end
    end

    // control and result state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 32; p++) begin
                r_pal[p] <= 8'h00;
            end
            r_count <= '0;
            r_obj   <= '0;
            r_byte  <= '0;
            r_n     <= '0;
            r_s     <= '0;
            r_hit   <= 1'b0;
            r_drawn <= 1'b0;
            r_cidx  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_obj   <= '0;
                r_byte  <= '0;
                r_n     <= '0;
                r_s     <= r_count;
                r_drawn <= 1'b0;
                r_cidx  <= '0;
            end
            if (i_cmd.exec) begin
                case (r_item.func)
                    FN_PAL_WR: r_pal[pal_widx] <= r_item.data;
                    FN_CLEAR:  r_hit <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.ev_take) begin
                if (r_byte == 2'd0) begin
                    if (ev_in_range) begin
                        r_byte <= 2'd1;
                    end else begin
                        r_obj <= r_obj + 1'b1;
                    end
                end else if (r_byte == 2'd3) begin
                    r_byte <= 2'd0;
                    r_n    <= n_plus;
                    r_obj  <= r_obj + 1'b1;
                end else begin
                    r_byte <= r_byte + 2'd1;
                end
                if (ev_end) begin
                    r_count <= (r_byte == 2'd3) ? n_plus : r_n;
                end
            end
            if (i_cmd.px_next || i_cmd.px_eval) begin
                r_s <= s_m1;
            end
            if (i_cmd.px_eval && (color != 2'd0)) begin
                if (r_slot_zero[s_idx] && (r_item.bg_index != 4'd0)
                    && (r_item.pixel_x != LAST_COLUMN)) begin
                    r_hit <= 1'b1;
                end
                if (i_cfg.show_bg && (!e_attr[5] || (r_item.bg_index == 4'd0))
                    && (r_item.line != PRE_RENDER_LINE)) begin
                    r_drawn <= 1'b1;
                    r_cidx  <= r_pal[pal_ridx][5:0];
                end
            end
        end
    end

    assign o_sts.func    = r_item.func;
    assign o_sts.ev_end  = ev_end;
    assign o_sts.px_none = !i_cfg.show_spr || (r_s == '0);
    assign o_sts.px_skip = px_skip;

    assign o_result.drawn = r_drawn;
    assign o_result.cidx  = r_drawn ? r_cidx : 6'd0;
    assign o_result.rgb   = r_drawn ? sys_color(r_cidx) : 24'd0;
    assign o_result.hit   = r_hit;
    assign o_result.count = 4'(r_count);

endmodule

`default_nettype wire

// ----- rtl/sprite_line_eval_and_pixel_compose_top.sv -----
// sprite_line_eval_and_pixel_compose_top: sprite evaluation and pixel composition unit
// depends on sle_pkg, sle_ctrl, sle_dp
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+----------------------------------------------
//  s (items) | in  | tvalid / tready    | tuser = func, tdata = address..bg_index
//  m (result)| out | tvalid / tready    | tuser = sprite_drawn, tdata = color..count
//  apb       | in  | psel/penable/pready| 5 one-bit control registers, 4-byte stride
//
// one transaction at a time: write, clear and unused items pass load, execute and done to the
// output register; an evaluate reads object bytes one at a time, each a read and a take step
// (first byte of each object, three more per selected sprite); a pixel skips a clipped slot in
// one check step, an unclipped one takes two pattern reads on the single pattern memory port
// synchronous active-low reset clears control, flags, palette and object-table valid bits
// the next transaction is taken while a result waits in the output register
`default_nettype none

module sprite_line_eval_and_pixel_compose_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // item channel
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [47:0] i_s_tdata,  // address[12:0] data[20:13] pixel_x[28:21]
                                    // line[38:29] bg_index[42:39], rest zero
    input  wire  [2:0]  i_s_tuser,  // func[2:0]
    // result channel
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [39:0] o_m_tdata,  // color_index[5:0] rgb[29:6] sprite0_hit[30]
                                    // sprites_on_line[34:31], rest zero
    output logic        o_m_tuser,  // sprite_drawn
    // control registers
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [4:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    import sle_pkg::*;

    t_cfg     r_cfg;
    t_item    item;
    t_cmd     cmd;
    t_sts     sts;
    t_result  res;
    t_result  r_out;
    logic     r_out_valid;
    logic     in_ready;
    logic     out_free;
    t_reg_idx reg_idx;
    logic     apb_wr;

    // unpack the incoming transaction
    assign item.func     = i_s_tuser;
    assign item.address  = i_s_tdata[12:0];
    assign item.data     = i_s_tdata[20:13];
    assign item.pixel_x  = i_s_tdata[28:21];
    assign item.line     = i_s_tdata[38:29];
    assign item.bg_index = i_s_tdata[42:39];

    // output register frees when empty or being taken
    assign out_free = !r_out_valid || i_m_tready;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (in_ready),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sle_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_result (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_out <= res;
        end
    end

    assign o_s_tready = in_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.drawn;
    assign o_m_tdata  = {5'd0, r_out.count, r_out.hit, r_out.rgb, r_out.cidx};

    // control registers, written in the access phase
    assign reg_idx = i_paddr[4:2];
    assign apb_wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_TALL:       r_cfg.tall       <= i_pwdata[0];
                REG_TABLE_HIGH: r_cfg.table_high <= i_pwdata[0];
                REG_SHOW_LEFT:  r_cfg.show_left  <= i_pwdata[0];
                REG_SHOW_BG:    r_cfg.show_bg    <= i_pwdata[0];
                REG_SHOW_SPR:   r_cfg.show_spr   <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_TALL:       o_prdata[0] = r_cfg.tall;
            REG_TABLE_HIGH: o_prdata[0] = r_cfg.table_high;
            REG_SHOW_LEFT:  o_prdata[0] = r_cfg.show_left;
            REG_SHOW_BG:    o_prdata[0] = r_cfg.show_bg;
            REG_SHOW_SPR:   o_prdata[0] = r_cfg.show_spr;
            default:        o_prdata    = '0;
        endcase
    end

    assign o_pready = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/sle_checker.sv -----
// sle_checker: port-level assertions for the sprite unit, bound to the top level
// depends on sle_pkg
`default_nettype none

module sle_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] o_m_tdata,
    input wire        o_m_tuser,
    input wire        o_pready
);
    import sle_pkg::*;

    // a result without a drawn pixel carries no color
    a_undrawn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[29:0] == 30'd0))
        else $error("undrawn result carries a color");

    // the rgb value matches the system color of the index
    a_rgb_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata[29:6] == sys_color(o_m_tdata[5:0])))
        else $error("rgb does not match color index");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("pready low");

endmodule

bind sprite_line_eval_and_pixel_compose_top sle_checker u_sle_checker (.*);

`default_nettype wire
